// ===== design/bssc_pkg.sv =====
package bssc_pkg;

    localparam int unsigned PWM_PERIOD_DEF       = 1000;
    localparam int unsigned TICK_RATE_HZ_DEF     = 10;
    localparam int unsigned MOTOR_POLE_PAIRS_DEF = 4;
    localparam int unsigned INITIAL_DUTY_DEF     = 0;

    localparam int unsigned DUTY_W    = 10;
    localparam int unsigned SPEED_W   = 24;
    localparam int unsigned PULSE_W   = 16;
    localparam int unsigned DUTY_FIELD_MAX = 1023;
    localparam int unsigned RPM_FACTOR     = 30;

    localparam logic [PULSE_W-1:0] PULSE_MAX = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    localparam logic [2:0] HALL_CODE_MASK = 3'b111;
    localparam logic [2:0] HALL_CODE_LOW  = 3'd0;
    localparam logic [2:0] HALL_CODE_HIGH = 3'd7;

    localparam logic [1:0] HALL_SRC_FIRST = 2'd0;
    localparam logic [1:0] HALL_SRC_NONE  = 2'd3;

    typedef enum logic [1:0] {
        CMD_HALL  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic [2:0] hall_levels;
        logic [1:0] hall_source;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  phase_a_duty;
        logic [DUTY_W-1:0]  phase_b_duty;
        logic [DUTY_W-1:0]  phase_c_duty;
        logic [DUTY_W-1:0]  general_duty;
        logic [2:0]         enable_mask;
        logic [2:0]         step;
        logic [SPEED_W-1:0] speed_rpm;
        logic [DUTY_W-1:0]  ramp_duty;
    } result_t;

    typedef struct packed {
        logic [2:0] step;
        logic [1:0] phase;
        logic [2:0] mask;
    } comm_t;

    // step, driven phase and bridge enables per hall code
    function automatic comm_t hall_decode(input logic [2:0] code);
        comm_t c;
        unique case (code)
            3'd1:    c = '{step: 3'd2, phase: 2'd0, mask: 3'd5};
            3'd2:    c = '{step: 3'd4, phase: 2'd1, mask: 3'd3};
            3'd3:    c = '{step: 3'd3, phase: 2'd1, mask: 3'd6};
            3'd4:    c = '{step: 3'd6, phase: 2'd2, mask: 3'd6};
            3'd5:    c = '{step: 3'd1, phase: 2'd0, mask: 3'd3};
            3'd6:    c = '{step: 3'd5, phase: 2'd2, mask: 3'd5};
            default: c = '{step: 3'd0, phase: 2'd0, mask: 3'd0};
        endcase
        return c;
    endfunction

endpackage

// ===== design/bldc_six_step_commutator_core.sv =====
// channel | dir | handshake         | payload
// s_      | in  | s_valid / s_ready | command, hall_levels, hall_source
// m_      | out | m_valid / m_ready | phase and general duties, enables, step, speed, ramp duty
// cfg_    | in  | cfg_wr_en         | reverse_direction on cfg_wr_data
//
// one event per cycle sustained while m_ready stays high; each result passes through
// the input register, then the state update into the result register
// the state registers are updated in the same cycle the result register is loaded
// synchronous active-low reset; all control state returns to its start values
// when m_ready is low with m_valid high the result register holds, and an empty input
// register still takes one more event before s_ready drops
module bldc_six_step_commutator_core #(
    parameter int unsigned PWM_PERIOD       = bssc_pkg::PWM_PERIOD_DEF,
    parameter int unsigned TICK_RATE_HZ     = bssc_pkg::TICK_RATE_HZ_DEF,
    parameter int unsigned MOTOR_POLE_PAIRS = bssc_pkg::MOTOR_POLE_PAIRS_DEF,
    parameter int unsigned INITIAL_DUTY     = bssc_pkg::INITIAL_DUTY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [2:0]                    s_hall_levels,
    input  logic [1:0]                    s_hall_source,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bssc_pkg::DUTY_W-1:0]   m_phase_a_duty,
    output logic [bssc_pkg::DUTY_W-1:0]   m_phase_b_duty,
    output logic [bssc_pkg::DUTY_W-1:0]   m_phase_c_duty,
    output logic [bssc_pkg::DUTY_W-1:0]   m_general_duty,
    output logic [2:0]                    m_enable_mask,
    output logic [2:0]                    m_step,
    output logic [bssc_pkg::SPEED_W-1:0]  m_speed_rpm,
    output logic [bssc_pkg::DUTY_W-1:0]   m_ramp_duty
);
    import bssc_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t m_result;

    assign s_item = '{
        command:     cmd_t'(s_command),
        hall_levels: s_hall_levels,
        hall_source: s_hall_source
    };

    // the held event moves on whenever the result register is free or drains
    assign advance = item_valid && (!m_valid || m_ready);

    bssc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bssc_engine #(
        .PWM_PERIOD       (PWM_PERIOD),
        .TICK_RATE_HZ     (TICK_RATE_HZ),
        .MOTOR_POLE_PAIRS (MOTOR_POLE_PAIRS),
        .INITIAL_DUTY     (INITIAL_DUTY)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (item),
        .result      (result)
    );

    bssc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .result   (result),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_result (m_result)
    );

    assign m_phase_a_duty = m_result.phase_a_duty;
    assign m_phase_b_duty = m_result.phase_b_duty;
    assign m_phase_c_duty = m_result.phase_c_duty;
    assign m_general_duty = m_result.general_duty;
    assign m_enable_mask  = m_result.enable_mask;
    assign m_step         = m_result.step;
    assign m_speed_rpm    = m_result.speed_rpm;
    assign m_ramp_duty    = m_result.ramp_duty;

endmodule

// ===== design/bssc_in_reg.sv =====
module bssc_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bssc_pkg::item_t s_item,
    input  logic           advance,
    output logic           item_valid,
    output bssc_pkg::item_t item
);
    import bssc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== design/bssc_engine.sv =====
module bssc_engine #(
    parameter int unsigned PWM_PERIOD       = bssc_pkg::PWM_PERIOD_DEF,
    parameter int unsigned TICK_RATE_HZ     = bssc_pkg::TICK_RATE_HZ_DEF,
    parameter int unsigned MOTOR_POLE_PAIRS = bssc_pkg::MOTOR_POLE_PAIRS_DEF,
    parameter int unsigned INITIAL_DUTY     = bssc_pkg::INITIAL_DUTY_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data,
    input  logic             advance,
    input  bssc_pkg::item_t  item,
    output bssc_pkg::result_t result
);
    import bssc_pkg::*;

    // rpm per pulse = RpmK / MOTOR_POLE_PAIRS, kept as quotient and remainder
    localparam int unsigned RpmK  = RPM_FACTOR * TICK_RATE_HZ;
    localparam int unsigned RpmKq = RpmK / MOTOR_POLE_PAIRS;
    localparam int unsigned RpmKr = RpmK % MOTOR_POLE_PAIRS;
    localparam longint unsigned RpmMax =
        longint'(PULSE_MAX) * longint'(RpmK) / longint'(MOTOR_POLE_PAIRS);
    localparam int RpmW  = $clog2(RpmMax + 1);
    localparam int RemW  = $clog2(MOTOR_POLE_PAIRS + 1);
    localparam int WideW = (RpmW > int'(SPEED_W)) ? RpmW : int'(SPEED_W);
    localparam int unsigned DutyLimit =
        (PWM_PERIOD > DUTY_FIELD_MAX) ? DUTY_FIELD_MAX : PWM_PERIOD;
    localparam logic [DUTY_W-1:0] DutyInit = DUTY_W'(INITIAL_DUTY & DUTY_FIELD_MAX);

    logic                reverse_reg;
    logic [DUTY_W-1:0]   duty_reg,     duty_mid;
    logic                ramp_reg,     ramp_next;
    logic                restart_reg,  restart_mid, restart_next;
    logic [PULSE_W-1:0]  pulse_reg,    pulse_next;
    logic [RpmW-1:0]     acc_q_reg,    acc_q_next;
    logic [RemW-1:0]     acc_r_reg,    acc_r_next;
    logic [SPEED_W-1:0]  speed_reg,    speed_next;
    logic [2:0]          step_reg,     step_next;
    logic [DUTY_W-1:0]   phase_reg  [3];
    logic [DUTY_W-1:0]   phase_next [3];
    logic [DUTY_W-1:0]   general_reg,  general_next;
    logic [2:0]          enables_reg,  enables_next;

    logic [RemW:0]       rem_sum;
    logic                rem_carry;
    logic [RpmW-1:0]     acc_q_inc;
    logic [RemW-1:0]     acc_r_inc;
    logic [WideW-1:0]    rpm_wide;
    logic [SPEED_W-1:0]  speed_sat;
    logic [2:0]          sensor_code;
    comm_t               comm;
    logic                code_valid;
    logic                hall_comm;
    logic                restart_fire;
    logic                do_comm;

    // one pulse worth of rpm added to the running quotient and remainder
    assign rem_sum   = (RemW+1)'(acc_r_reg) + (RemW+1)'(RpmKr);
    assign rem_carry = rem_sum >= (RemW+1)'(MOTOR_POLE_PAIRS);
    assign acc_r_inc = rem_carry ? RemW'(rem_sum - (RemW+1)'(MOTOR_POLE_PAIRS))
                                 : RemW'(rem_sum);
    assign acc_q_inc = acc_q_reg + RpmW'(RpmKq) + RpmW'(rem_carry);

    assign rpm_wide  = WideW'(acc_q_reg);
    assign speed_sat = (rpm_wide > WideW'(SPEED_MAX)) ? SPEED_MAX : rpm_wide[SPEED_W-1:0];

    assign sensor_code = (item.hall_levels & HALL_CODE_MASK) ^ {3{reverse_reg}};
    assign comm        = hall_decode(sensor_code);
    assign code_valid  = (sensor_code != HALL_CODE_LOW) && (sensor_code != HALL_CODE_HIGH);

    always_comb begin
        duty_mid    = duty_reg;
        ramp_next   = ramp_reg;
        restart_mid = restart_reg;
        pulse_next  = pulse_reg;
        acc_q_next  = acc_q_reg;
        acc_r_next  = acc_r_reg;
        speed_next  = speed_reg;
        hall_comm   = 1'b0;
        unique case (item.command)
            CMD_HALL: begin
                if (item.hall_source != HALL_SRC_NONE) begin
                    hall_comm = 1'b1;
                    if (item.hall_source == HALL_SRC_FIRST && pulse_reg != PULSE_MAX) begin
                        pulse_next = pulse_reg + PULSE_W'(1);
                        acc_q_next = acc_q_inc;
                        acc_r_next = acc_r_inc;
                    end
                end
            end
            CMD_TICK: begin
                speed_next = speed_sat;
                pulse_next = '0;
                acc_q_next = '0;
                acc_r_next = '0;
                if (ramp_reg) begin
                    if (duty_reg == '0 || speed_sat == '0) begin
                        restart_mid = 1'b1;
                    end
                    if (duty_reg < DUTY_W'(DutyLimit)) begin
                        duty_mid = duty_reg + DUTY_W'(1);
                    end
                end
            end
            CMD_START: begin
                ramp_next = 1'b1;
            end
            CMD_STOP: begin
                duty_mid  = '0;
                ramp_next = 1'b0;
            end
        endcase

        restart_fire = restart_mid && (duty_mid != '0);
        restart_next = restart_mid && !restart_fire;
        // a hall edge and a restart in the same item drive the same phases
        do_comm      = hall_comm || restart_fire;

        general_next = general_reg;
        step_next    = step_reg;
        enables_next = enables_reg;
        for (int i = 0; i < 3; i++) begin
            phase_next[i] = phase_reg[i];
        end
        if (do_comm) begin
            general_next = duty_mid;
            if (code_valid) begin
                step_next    = comm.step;
                enables_next = comm.mask;
                for (int i = 0; i < 3; i++) begin
                    phase_next[i] = (comm.phase == 2'(i)) ? duty_mid : '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reverse_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            reverse_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg    <= DutyInit;
            ramp_reg    <= 1'b0;
            restart_reg <= 1'b0;
            pulse_reg   <= '0;
            acc_q_reg   <= '0;
            acc_r_reg   <= '0;
            speed_reg   <= '0;
            step_reg    <= '0;
            general_reg <= '0;
            enables_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                phase_reg[i] <= '0;
            end
        end else if (advance) begin
            duty_reg    <= duty_mid;
            ramp_reg    <= ramp_next;
            restart_reg <= restart_next;
            pulse_reg   <= pulse_next;
            acc_q_reg   <= acc_q_next;
            acc_r_reg   <= acc_r_next;
            speed_reg   <= speed_next;
            step_reg    <= step_next;
            general_reg <= general_next;
            enables_reg <= enables_next;
            for (int i = 0; i < 3; i++) begin
                phase_reg[i] <= phase_next[i];
            end
        end
    end

    assign result = '{
        phase_a_duty: phase_next[0],
        phase_b_duty: phase_next[1],
        phase_c_duty: phase_next[2],
        general_duty: general_next,
        enable_mask:  enables_next,
        step:         step_next,
        speed_rpm:    speed_next,
        ramp_duty:    duty_mid
    };

    a_step_enables: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == '0) |-> (enables_reg == '0))
        else $error("bridge enabled before first commutation");

    a_two_bridges: assert property (@(posedge aclk) disable iff (!aresetn)
        (enables_reg == '0) || ($countones(enables_reg) == 2))
        else $error("enable mask does not select two half-bridges");

    a_one_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({phase_reg[0] != '0, phase_reg[1] != '0, phase_reg[2] != '0}) <= 1)
        else $error("more than one phase carries duty");

    a_restart_served: assert property (@(posedge aclk) disable iff (!aresetn)
        !(restart_reg && duty_reg != '0))
        else $error("restart left pending with nonzero duty");

endmodule

// ===== design/bssc_out_reg.sv =====
module bssc_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  bssc_pkg::result_t result,
    input  logic              m_ready,
    output logic              m_valid,
    output bssc_pkg::result_t m_result
);
    import bssc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import bssc_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 90;
    localparam int HOLD_BURST    = 12;

    localparam logic [1:0] SRC_SECOND = 2'd1;
    localparam logic [1:0] SRC_THIRD  = 2'd2;

    localparam logic [DUTY_W-1:0] DUTY_TOP =
        DUTY_W'((PWM_PERIOD_DEF > DUTY_FIELD_MAX) ? DUTY_FIELD_MAX : PWM_PERIOD_DEF);

    // per hall code, listed from code 7 down to code 0
    localparam logic [7:0][2:0] STEP_OF_CODE  = {3'd0, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4, 3'd2, 3'd0};
    localparam logic [7:0][1:0] PHASE_OF_CODE = {2'd0, 2'd2, 2'd0, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
    localparam logic [7:0][2:0] MASK_OF_CODE  = {3'd0, 3'd5, 3'd3, 3'd6, 3'd6, 3'd3, 3'd5, 3'd0};

    // hall levels in forward rotation order, step 1 first
    localparam logic [5:0][2:0] HALL_SEQ = {3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5};

    typedef struct {
        cmd_t       cmd;
        logic [2:0] levels;
        logic [1:0] source;
        bit         typed;
        result_t    want;
    } drive_row_t;

    logic aclk        = 1'b0;
    logic aresetn     = 1'b0;
    logic cfg_wr_en   = 1'b0;
    logic cfg_wr_data = 1'b0;

    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [1:0] s_command     = 2'd0;
    logic [2:0] s_hall_levels = 3'd0;
    logic [1:0] s_hall_source = 2'd0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [DUTY_W-1:0]  m_phase_a_duty;
    logic [DUTY_W-1:0]  m_phase_b_duty;
    logic [DUTY_W-1:0]  m_phase_c_duty;
    logic [DUTY_W-1:0]  m_general_duty;
    logic [2:0]         m_enable_mask;
    logic [2:0]         m_step;
    logic [SPEED_W-1:0] m_speed_rpm;
    logic [DUTY_W-1:0]  m_ramp_duty;

    // predicted drive state
    bit                         reverse_q;
    logic [DUTY_W-1:0]          duty_q;
    bit                         ramp_on;
    bit                         restart_armed;
    logic [PULSE_W-1:0]         pulses_q;
    logic [SPEED_W-1:0]         speed_q;
    logic [2:0]                 step_q;
    logic [2:0][DUTY_W-1:0]     phase_duty_q;
    logic [DUTY_W-1:0]          general_q;
    logic [2:0]                 bridge_q;

    result_t    drive_expected[$];
    drive_row_t plan[$];

    bit sender_calm = 1'b0;
    bit sink_calm   = 1'b0;
    bit hold_req    = 1'b0;
    int hall_pos    = 0;

    int events_sent  = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int writes_done  = 0;
    int quiet_cycles = 0;

    logic [DUTY_W-1:0]  peak_duty  = '0;
    logic [SPEED_W-1:0] peak_speed = '0;

    bldc_six_step_commutator_core #(
        .PWM_PERIOD       (PWM_PERIOD_DEF),
        .TICK_RATE_HZ     (TICK_RATE_HZ_DEF),
        .MOTOR_POLE_PAIRS (MOTOR_POLE_PAIRS_DEF),
        .INITIAL_DUTY     (INITIAL_DUTY_DEF)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_hall_levels  (s_hall_levels),
        .s_hall_source  (s_hall_source),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_phase_a_duty (m_phase_a_duty),
        .m_phase_b_duty (m_phase_b_duty),
        .m_phase_c_duty (m_phase_c_duty),
        .m_general_duty (m_general_duty),
        .m_enable_mask  (m_enable_mask),
        .m_step         (m_step),
        .m_speed_rpm    (m_speed_rpm),
        .m_ramp_duty    (m_ramp_duty)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void reset_model();
        reverse_q     = 1'b0;
        duty_q        = DUTY_W'(INITIAL_DUTY_DEF & DUTY_FIELD_MAX);
        ramp_on       = 1'b0;
        restart_armed = 1'b0;
        pulses_q      = '0;
        speed_q       = '0;
        step_q        = '0;
        phase_duty_q  = '0;
        general_q     = '0;
        bridge_q      = '0;
    endfunction

    function automatic void commutate_model(input logic [2:0] levels);
        logic [2:0] code;
        code = reverse_q ? ~levels : levels;
        // codes 0 and 7 keep the last drive, only the general channel follows
        if (code != HALL_CODE_LOW && code != HALL_CODE_HIGH) begin
            step_q       = STEP_OF_CODE[code];
            phase_duty_q = '0;
            phase_duty_q[PHASE_OF_CODE[code]] = duty_q;
            bridge_q     = MASK_OF_CODE[code];
        end
        general_q = duty_q;
    endfunction

    function automatic result_t advance_drive(input cmd_t cmd, input logic [2:0] levels,
                                              input logic [1:0] source);
        longint unsigned rpm;
        result_t r;
        case (cmd)
            CMD_HALL: begin
                if (source != HALL_SRC_NONE) begin
                    if (source == HALL_SRC_FIRST && pulses_q != PULSE_MAX)
                        pulses_q = pulses_q + 16'd1;
                    commutate_model(levels);
                end
            end
            CMD_TICK: begin
                rpm = 64'(pulses_q) * 64'(RPM_FACTOR) * 64'(TICK_RATE_HZ_DEF)
                      / 64'(MOTOR_POLE_PAIRS_DEF);
                speed_q  = (rpm > 64'(SPEED_MAX)) ? SPEED_MAX : rpm[SPEED_W-1:0];
                pulses_q = '0;
                if (ramp_on) begin
                    if (duty_q == '0 || speed_q == '0)
                        restart_armed = 1'b1;
                    if (duty_q < DUTY_TOP)
                        duty_q = duty_q + 10'd1;
                end
            end
            CMD_START: ramp_on = 1'b1;
            CMD_STOP: begin
                duty_q  = '0;
                ramp_on = 1'b0;
            end
        endcase
        if (restart_armed && duty_q != '0) begin
            commutate_model(levels);
            restart_armed = 1'b0;
        end
        if (duty_q > peak_duty)
            peak_duty = duty_q;
        if (speed_q > peak_speed)
            peak_speed = speed_q;
        r.phase_a_duty = phase_duty_q[0];
        r.phase_b_duty = phase_duty_q[1];
        r.phase_c_duty = phase_duty_q[2];
        r.general_duty = general_q;
        r.enable_mask  = bridge_q;
        r.step         = step_q;
        r.speed_rpm    = speed_q;
        r.ramp_duty    = duty_q;
        return r;
    endfunction

    function automatic result_t drive_word(input int a, input int b, input int c, input int g,
                                           input int mask, input int st, input int speed,
                                           input int duty);
        result_t r;
        r.phase_a_duty = DUTY_W'(a);
        r.phase_b_duty = DUTY_W'(b);
        r.phase_c_duty = DUTY_W'(c);
        r.general_duty = DUTY_W'(g);
        r.enable_mask  = 3'(mask);
        r.step         = 3'(st);
        r.speed_rpm    = SPEED_W'(speed);
        r.ramp_duty    = DUTY_W'(duty);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly follows the rotation, sometimes backs up or jumps anywhere
    function automatic logic [2:0] next_levels();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 3'($urandom_range(0, 7));
        if (r < 25)
            hall_pos = (hall_pos + 5) % 6;
        else
            hall_pos = (hall_pos + 1) % 6;
        return HALL_SEQ[3'(hall_pos)];
    endfunction

    task automatic add_row(input cmd_t cmd, input logic [2:0] levels, input logic [1:0] source,
                           input bit typed, input result_t want);
        drive_row_t row;
        row.cmd    = cmd;
        row.levels = levels;
        row.source = source;
        row.typed  = typed;
        row.want   = want;
        plan.push_back(row);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic send_event(input cmd_t cmd, input logic [2:0] levels,
                              input logic [1:0] source, input bit typed, input result_t want);
        int gap;
        result_t predicted;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_hall_levels <= levels;
        s_hall_source <= source;
        do @(posedge aclk); while (!s_ready);
        predicted = advance_drive(cmd, levels, source);
        drive_expected.push_back(typed ? want : predicted);
        events_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (drive_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_direction(input bit rev);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= rev;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        reverse_q = rev;
        writes_done++;
    endtask

    task automatic random_event(output cmd_t cmd, output logic [2:0] levels,
                                output logic [1:0] source);
        int r;
        r      = $urandom_range(0, 99);
        levels = next_levels();
        source = 2'($urandom_range(0, 3));
        if (r < 55) begin
            cmd = CMD_HALL;
            r   = $urandom_range(0, 19);
            if (r < 12)
                source = HALL_SRC_FIRST;
            else if (r < 19)
                source = ($urandom_range(0, 1) == 0) ? SRC_SECOND : SRC_THIRD;
            else
                source = HALL_SRC_NONE;
        end else if (r < 80) begin
            cmd = CMD_TICK;
        end else if (r < 92) begin
            cmd = CMD_START;
        end else begin
            cmd = CMD_STOP;
        end
    endtask

    task automatic run_random(input int count, input bit with_hold);
        cmd_t cmd;
        logic [2:0] levels;
        logic [1:0] source;
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 2) begin
                // sink stalls while the source keeps offering back to back
                wait_drained();
                @(negedge aclk);
                hold_req = 1'b1;
                @(posedge aclk);
                sender_calm = 1'b1;
                repeat (HOLD_BURST) begin
                    random_event(cmd, levels, source);
                    send_event(cmd, levels, source, 1'b0, '0);
                end
                sender_calm = 1'b0;
            end
            random_event(cmd, levels, source);
            send_event(cmd, levels, source, 1'b0, '0);
        end
    endtask

    task automatic check_drive();
        result_t want;
        results_seen++;
        if (drive_expected.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
            return;
        end
        want = drive_expected.pop_front();
        if (m_phase_a_duty !== want.phase_a_duty)
            report_mismatch($sformatf("phase_a_duty got %0d want %0d",
                                      m_phase_a_duty, want.phase_a_duty));
        if (m_phase_b_duty !== want.phase_b_duty)
            report_mismatch($sformatf("phase_b_duty got %0d want %0d",
                                      m_phase_b_duty, want.phase_b_duty));
        if (m_phase_c_duty !== want.phase_c_duty)
            report_mismatch($sformatf("phase_c_duty got %0d want %0d",
                                      m_phase_c_duty, want.phase_c_duty));
        if (m_general_duty !== want.general_duty)
            report_mismatch($sformatf("general_duty got %0d want %0d",
                                      m_general_duty, want.general_duty));
        if (m_enable_mask !== want.enable_mask)
            report_mismatch($sformatf("enable_mask got %0d want %0d",
                                      m_enable_mask, want.enable_mask));
        if (m_step !== want.step)
            report_mismatch($sformatf("step got %0d want %0d", m_step, want.step));
        if (m_speed_rpm !== want.speed_rpm)
            report_mismatch($sformatf("speed_rpm got %0d want %0d",
                                      m_speed_rpm, want.speed_rpm));
        if (m_ramp_duty !== want.ramp_duty)
            report_mismatch($sformatf("ramp_duty got %0d want %0d",
                                      m_ramp_duty, want.ramp_duty));
    endtask

    initial begin : result_sink
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                check_drive();
            if (hold_req) begin
                hold_req = 1'b0;
                idle = HOLD_CYCLES;
            end else if (idle == 0 && !sink_calm && $urandom_range(0, 3) == 0) begin
                idle = pick_gap();
            end
            if (idle > 0) begin
                m_ready <= 1'b0;
                idle--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, drive_expected.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int extra;
        reset_model();

        // after reset, code 5 on the first sensor, then keep-codes and an ignored source
        add_row(CMD_HALL,  3'd5, HALL_SRC_FIRST, 1'b1, drive_word(0, 0, 0, 0, 3, 1, 0, 0));
        add_row(CMD_HALL,  3'd7, SRC_SECOND,     1'b1, drive_word(0, 0, 0, 0, 3, 1, 0, 0));
        add_row(CMD_HALL,  3'd0, SRC_THIRD,      1'b1, drive_word(0, 0, 0, 0, 3, 1, 0, 0));
        add_row(CMD_HALL,  3'd3, HALL_SRC_NONE,  1'b1, drive_word(0, 0, 0, 0, 3, 1, 0, 0));
        // one pulse gives 75 rpm
        add_row(CMD_TICK,  3'd1, HALL_SRC_FIRST, 1'b1, drive_word(0, 0, 0, 0, 3, 1, 75, 0));
        add_row(CMD_START, 3'd6, SRC_SECOND,     1'b1, drive_word(0, 0, 0, 0, 3, 1, 75, 0));
        // zero duty and speed arm a restart, which drives code 1 at duty 1
        add_row(CMD_TICK,  3'd1, SRC_THIRD,      1'b1, drive_word(1, 0, 0, 1, 5, 2, 0, 1));
        add_row(CMD_START, 3'd4, HALL_SRC_NONE,  1'b0, '0);
        add_row(CMD_HALL,  3'd2, SRC_SECOND,     1'b0, '0);
        add_row(CMD_HALL,  3'd3, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_HALL,  3'd1, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_TICK,  3'd6, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_HALL,  3'd6, SRC_THIRD,      1'b0, '0);
        add_row(CMD_HALL,  3'd4, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_HALL,  3'd7, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_TICK,  3'd0, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_STOP,  3'd5, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_HALL,  3'd5, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_TICK,  3'd7, HALL_SRC_NONE,  1'b0, '0);
        add_row(CMD_TICK,  3'd2, SRC_SECOND,     1'b0, '0);
        add_row(CMD_STOP,  3'd0, HALL_SRC_FIRST, 1'b0, '0);
        add_row(CMD_START, 3'd1, SRC_THIRD,      1'b0, '0);
        add_row(CMD_TICK,  3'd5, SRC_SECOND,     1'b0, '0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_direction(1'b0);
        foreach (plan[i])
            send_event(plan[i].cmd, plan[i].levels, plan[i].source, plan[i].typed, plan[i].want);

        write_direction(1'b1);
        run_random(120, 1'b1);

        // a stretch with no idling on either side
        write_direction(1'b0);
        sender_calm = 1'b1;
        sink_calm   = 1'b1;
        run_random(120, 1'b0);
        sender_calm = 1'b0;
        sink_calm   = 1'b0;

        // ramp the duty all the way to its ceiling and sit there
        write_direction(1'b1);
        send_event(CMD_STOP, next_levels(), HALL_SRC_FIRST, 1'b0, '0);
        send_event(CMD_START, next_levels(), HALL_SRC_FIRST, 1'b0, '0);
        extra = 0;
        while (extra < 20) begin
            if ($urandom_range(0, 4) == 0)
                send_event(CMD_HALL, next_levels(), 2'($urandom_range(0, 2)), 1'b0, '0);
            else
                send_event(CMD_TICK, next_levels(), 2'($urandom_range(0, 3)), 1'b0, '0);
            if (duty_q == DUTY_TOP)
                extra++;
        end

        write_direction(1'b0);
        run_random(120, 1'b0);

        write_direction(1'b1);
        run_random(120, 1'b1);

        wait_drained();
        if (drive_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", drive_expected.size()));

        $display("sent %0d events, checked %0d results, %0d direction writes",
                 events_sent, results_seen, writes_done);
        $display("ramp duty peaked at %0d, speed peaked at %0d rpm, mismatches %0d",
                 peak_duty, peak_speed, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
